### hdl/rpsab_pkg.sv
// Shared types and constants for the RGB pixel store with alpha blend.
`default_nettype none
package rpsab_pkg;

  // commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_LINE  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_POINT   = 2'd2;
  localparam logic [1:0] ST_DIAG    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ALPHA  = 2'd2;

  // line shapes
  localparam logic [1:0] LINE_HORIZ = 2'd0;
  localparam logic [1:0] LINE_VERT  = 2'd1;
  localparam logic [1:0] LINE_DIAG  = 2'd2;

  localparam int CW      = 14;  // internal coordinate width, two's complement
  localparam int IN_CW   = 11;  // coordinate width on the ports
  localparam int SIZE_W  = 10;  // width of the size registers

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic rd;
    logic wr_pix;
    logic mul;
    logic wr_blend;
    logic line_init;
    logic line_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] cmd;
    logic       in_image;
    logic       blend;
    logic       skip;
    logic [1:0] line_kind;
    logic       line_last;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

### hdl/rgb_pixel_store_alpha_blend.sv
// Top level of the RGB pixel store with alpha-blended writes and line draws.
`default_nettype none
// A frame store of MAX_WIDTH x MAX_HEIGHT 24-bit pixels behind one single-port
// memory. After reset the store is swept to zero one pixel a cycle; in_stall
// stays high for the whole sweep while config writes are still taken. One word
// is worked on at a time: a plain pixel write, a pixel read, a skipped write or
// a diagonal line goes from accept through the decode and done states, and the
// next word is taken once its result is registered; a blended write adds a
// multiply state, then a state that divides and writes back; a horizontal or
// vertical line adds a line state that steps along its span, as the single
// store port writes one pixel a cycle. The result register lets the next word
// be accepted while the last result waits.
module rgb_pixel_store_alpha_blend
  import rpsab_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [SIZE_W-1:0]  cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         command,
  input  wire logic [IN_CW-1:0]   x_first,
  input  wire logic [IN_CW-1:0]   y_first,
  input  wire logic [IN_CW-1:0]   x_second,
  input  wire logic [IN_CW-1:0]   y_second,
  input  wire logic [7:0]         red_in,
  input  wire logic [7:0]         green_in,
  input  wire logic [7:0]         blue_in,
  input  wire logic [7:0]         alpha_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              red_out,
  output logic [7:0]              green_out,
  output logic [7:0]              blue_out,
  output logic [1:0]              status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rpsab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpsab_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (command),
    .x_first   (x_first),
    .y_first   (y_first),
    .x_second  (x_second),
    .y_second  (y_second),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .status    (status)
  );

`ifndef SYNTHESIS
  // an accepted word blocks the input until it is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous word in flight");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result register overwritten");

  // blended write-back follows the multiply stage
  a_blend_order: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_blend |-> $past(cmd.mul))
    else $error("blend write without product stage");
`endif

endmodule
`default_nettype wire

### hdl/rpsab_ctrl.sv
// Controller state machine: sequences clearing, writes, reads and line draws.
`default_nettype none
module rpsab_ctrl
  import rpsab_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_BLEND  = 3'd4;
  localparam logic [2:0] S_LINE   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_WRITE: begin
            if (!stat.in_image || stat.skip) begin
              state_next = S_DONE;
            end else if (stat.blend) begin
              cmd.rd     = 1'b1;
              state_next = S_MUL;
            end else begin
              cmd.wr_pix = 1'b1;
              state_next = S_DONE;
            end
          end
          CMD_READ: begin
            cmd.rd     = 1'b1;
            state_next = S_DONE;
          end
          CMD_LINE: begin
            if (stat.line_kind == LINE_DIAG) begin
              state_next = S_DONE;
            end else begin
              cmd.line_init = 1'b1;
              state_next    = S_LINE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_BLEND;
      end
      S_BLEND: begin
        cmd.wr_blend = 1'b1;
        state_next   = S_DONE;
      end
      S_LINE: begin
        cmd.line_step = 1'b1;
        if (stat.line_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### hdl/rpsab_dp.sv
// Datapath: frame store, config registers, coordinate logic, blend and result register.
`default_nettype none
module rpsab_dp
  import rpsab_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             cmd,
  output dp_stat_t                 stat,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [SIZE_W-1:0]   cfg_data,
  input  wire logic [1:0]          command,
  input  wire logic [IN_CW-1:0]    x_first,
  input  wire logic [IN_CW-1:0]    y_first,
  input  wire logic [IN_CW-1:0]    x_second,
  input  wire logic [IN_CW-1:0]    y_second,
  input  wire logic [7:0]          red_in,
  input  wire logic [7:0]          green_in,
  input  wire logic [7:0]          blue_in,
  input  wire logic [7:0]          alpha_in,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               red_out,
  output logic [7:0]               green_out,
  output logic [7:0]               blue_out,
  output logic [1:0]               status
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  function automatic logic [CW-1:0] sext(input logic [IN_CW-1:0] v);
    return {{(CW-IN_CW){v[IN_CW-1]}}, v};
  endfunction

  // exact n/255 for n up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [16:0] t;
    t = {1'b0, n} + 17'd1 + {9'd0, n[15:8]};
    return t[15:8];
  endfunction

  function automatic logic lt_s(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // configuration
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic              alpha_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= SIZE_W'(512);
      height_r <= SIZE_W'(512);
      alpha_en <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_ALPHA:  alpha_en <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  logic [CW-1:0] w_eff;
  logic [CW-1:0] h_eff;

  always_comb begin
    if (width_r == '0)                       w_eff = CW'(1);
    else if (CW'(width_r) > CW'(MAX_WIDTH))  w_eff = CW'(MAX_WIDTH);
    else                                     w_eff = CW'(width_r);
    if (height_r == '0)                      h_eff = CW'(1);
    else if (CW'(height_r) > CW'(MAX_HEIGHT)) h_eff = CW'(MAX_HEIGHT);
    else                                     h_eff = CW'(height_r);
  end

  // latched word
  logic [1:0]    cmd_r;
  logic [CW-1:0] x0;
  logic [CW-1:0] y0;
  logic [CW-1:0] x1;
  logic [CW-1:0] y1;
  rgb_t          rgb_r;
  logic [7:0]    alpha_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= command;
      x0      <= sext(x_first);
      y0      <= sext(y_first);
      x1      <= sext(x_second);
      y1      <= sext(y_second);
      rgb_r   <= {red_in, green_in, blue_in};
      alpha_r <= alpha_in;
    end
  end

  // line shape and span
  logic          is_point;
  logic [1:0]    line_kind;
  logic [CW-1:0] span_lo;
  logic [CW-1:0] span_hi;
  logic [CW-1:0] k;

  always_comb begin
    is_point = (x0 == x1) && (y0 == y1);
    if (y0 == y1)      line_kind = LINE_HORIZ;
    else if (x0 == x1) line_kind = LINE_VERT;
    else               line_kind = LINE_DIAG;
    if (line_kind == LINE_HORIZ) begin
      span_lo = lt_s(x0, x1) ? x0 : x1;
      span_hi = lt_s(x0, x1) ? x1 : x0;
    end else begin
      span_lo = lt_s(y0, y1) ? y0 : y1;
      span_hi = lt_s(y0, y1) ? y1 : y0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.line_init)      k <= span_lo;
    else if (cmd.line_step) k <= k + CW'(1);
  end

  // pixel coordinates for the current operation
  logic [CW-1:0] px;
  logic [CW-1:0] py;
  logic          in_image;

  always_comb begin
    px = x0;
    py = y0;
    case (cmd_r)
      CMD_READ: begin
        if (px[CW-1])           px = '0;
        else if (px >= w_eff)   px = w_eff - CW'(1);
        if (py[CW-1])           py = '0;
        else if (py >= h_eff)   py = h_eff - CW'(1);
      end
      CMD_LINE: begin
        // rows count from the bottom
        if (line_kind == LINE_HORIZ) begin
          px = k;
          py = h_eff - CW'(1) - y0;
        end else begin
          px = x0;
          py = h_eff - CW'(1) - k;
        end
      end
      default: ;
    endcase
    in_image = !px[CW-1] && !py[CW-1] && (px < w_eff) && (py < h_eff);
  end

  logic [AW-1:0] pix_addr;
  assign pix_addr = AW'(AW'(py[YW-1:0]) * AW'(MAX_WIDTH)) + AW'(px[XW-1:0]);

  // clearing sweep
  logic [AW-1:0] clr_cnt;
  logic          clr_last;
  assign clr_last = (clr_cnt == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst)               clr_cnt <= '0;
    else if (cmd.clr_step) clr_cnt <= clr_cnt + AW'(1);
  end

  // blend: products summed and registered, then divided on the write
  rgb_t        rd_data;
  logic [15:0] sum_r [3];
  rgb_t        blended;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int c = 0; c < 3; c++) begin
        sum_r[c] <= 16'({8'd0, rd_data[c*8 +: 8]} * {8'd0, 8'd255 - alpha_r})
                  + 16'({8'd0, rgb_r[c*8 +: 8]} * {8'd0, alpha_r});
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      blended[c*8 +: 8] = div255(sum_r[c]);
    end
  end

  // frame store
  rgb_t          mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  rgb_t          mem_wdata;

  always_comb begin
    mem_addr  = cmd.clr_step ? clr_cnt : pix_addr;
    mem_we    = cmd.clr_step || cmd.wr_blend ||
                ((cmd.wr_pix || cmd.line_step) && in_image);
    if (cmd.clr_step)      mem_wdata = '0;
    else if (cmd.wr_blend) mem_wdata = blended;
    else                   mem_wdata = rgb_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (cmd.rd) rd_data <= mem[mem_addr];
  end

  // result register
  logic [1:0] status_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (cmd_r)
      CMD_WRITE: status_next = in_image ? ST_DONE : ST_OUTSIDE;
      CMD_LINE: begin
        if (is_point)                    status_next = ST_POINT;
        else if (line_kind == LINE_DIAG) status_next = ST_DIAG;
        else                             status_next = ST_DONE;
      end
      default: status_next = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= status_next;
      if (cmd_r == CMD_READ) begin
        red_out   <= rd_data[23:16];
        green_out <= rd_data[15:8];
        blue_out  <= rd_data[7:0];
      end else begin
        red_out   <= '0;
        green_out <= '0;
        blue_out  <= '0;
      end
    end
  end

  always_comb begin
    stat.clr_last  = clr_last;
    stat.cmd       = cmd_r;
    stat.in_image  = in_image;
    stat.blend     = alpha_en && (alpha_r != 8'd255) && (alpha_r != 8'd0);
    stat.skip      = alpha_en && (alpha_r == 8'd0);
    stat.line_kind = line_kind;
    stat.line_last = (k == span_hi);
    stat.out_free  = out_free;
  end

endmodule
`default_nettype wire
